### hw/rtl/mrfe_pkg.sv
// shared types, codes and the crc-16 byte update for the modbus read frame engine
// no dependencies
package mrfe_pkg;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int RX_CNT_W = 4;
  localparam int TX_IDX_W = 3;

  localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

  // input opcodes
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RX_BYTE = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // result kinds
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // report status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_RESP = 2'd1;
  localparam logic [1:0] ST_CRC_ERR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_CODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_REGISTER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_COUNT = 2'd3;

  // receive byte positions
  localparam logic [RX_CNT_W-1:0] RX_FIRST_DATA = 4'd3;
  localparam logic [RX_CNT_W-1:0] RX_CRC_LOW    = 4'd7;
  localparam logic [RX_CNT_W-1:0] RX_CRC_HIGH   = 4'd8;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] tx_byte;
    logic              last;
    logic [1:0]        status;
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] second_word;
  } out_item_t;

  // report from the response checker, valid on the ninth byte
  typedef struct packed {
    logic              valid;
    logic              good;
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] second_word;
  } rx_rpt_t;

  function automatic logic [WORD_W-1:0] crc16_byte(input logic [WORD_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### hw/rtl/mrfe_in_if.sv
// input channel: opcode and received byte with valid/ready
// depends on mrfe_pkg
interface mrfe_in_if import mrfe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

### hw/rtl/mrfe_out_if.sv
// result channel: transmit bytes and response reports with valid/ready
// depends on mrfe_pkg
interface mrfe_out_if import mrfe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] tx_byte;
  logic              last;
  logic [1:0]        status;
  logic [WORD_W-1:0] first_word;
  logic [WORD_W-1:0] second_word;

  modport source (output valid, output kind, output tx_byte, output last, output status,
                  output first_word, output second_word, input ready);
  modport sink (input valid, input kind, input tx_byte, input last, input status,
                input first_word, input second_word, output ready);
endinterface

### hw/rtl/mrfe_rx_check.sv
// response receiver: running crc, data byte capture and ninth-byte check
// depends on mrfe_pkg
module mrfe_rx_check import mrfe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              restart,
  input  logic              take,
  input  logic [BYTE_W-1:0] rx_byte,
  output rx_rpt_t           rpt
);

  logic [RX_CNT_W-1:0] count_r, count_nxt;
  logic [WORD_W-1:0]   crc_r, crc_nxt;
  logic [BYTE_W-1:0]   data_r [4];
  logic [BYTE_W-1:0]   crc_lo_r;
  logic [RX_CNT_W-1:0] data_pos;

  assign data_pos = count_r - RX_FIRST_DATA;

  always_comb begin
    count_nxt = count_r;
    crc_nxt   = crc_r;
    rpt.valid = 1'b0;
    rpt.good  = (crc_lo_r == crc_r[7:0]) && (rx_byte == crc_r[15:8]);
    rpt.first_word  = {data_r[0], data_r[1]};
    rpt.second_word = {data_r[2], data_r[3]};
    if (restart) begin
      count_nxt = '0;
      crc_nxt   = CRC_INIT;
    end else if (take) begin
      if (count_r < RX_CRC_LOW) begin
        crc_nxt   = crc16_byte(crc_r, rx_byte);
        count_nxt = count_r + 4'd1;
      end else if (count_r == RX_CRC_LOW) begin
        count_nxt = RX_CRC_HIGH;
      end else begin
        // ninth byte closes the frame
        rpt.valid = 1'b1;
        count_nxt = '0;
        crc_nxt   = CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      crc_r   <= CRC_INIT;
    end else begin
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!restart && take) begin
      if (count_r < RX_CRC_LOW && count_r >= RX_FIRST_DATA) begin
        data_r[data_pos[1:0]] <= rx_byte;
      end
      if (count_r == RX_CRC_LOW) begin
        crc_lo_r <= rx_byte;
      end
    end
  end

endmodule

### hw/rtl/modbus_read_frame_engine.sv
// Modbus RTU read-request framer and response checker. A request beat produces eight
// transmit beats, one per cycle whenever the output register is empty or being drained,
// while the input is held off; the CRC-16 is folded in one byte per transmit beat as
// the first six bytes go out. Response bytes and timeouts are taken one per cycle whenever
// no frame is being sent and the single output register is empty or being drained; the
// ninth response byte and a timeout each give one report beat. A new request is not taken
// until all eight transmit beats of the last one have gone into the output register.
// depends on mrfe_pkg, mrfe_in_if, mrfe_out_if, mrfe_rx_check
module modbus_read_frame_engine import mrfe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mrfe_in_if.sink               in_ch,
  mrfe_out_if.source            out_ch
);

  logic [BYTE_W-1:0] dev_addr_r, func_code_r;
  logic [WORD_W-1:0] start_reg_r, reg_count_r;

  logic                tx_busy_r, tx_busy_nxt;
  logic [TX_IDX_W-1:0] tx_idx_r, tx_idx_nxt;
  logic [WORD_W-1:0]   tx_crc_r, tx_crc_nxt;
  logic [BYTE_W-1:0]   tx_sel;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic    slot_free, in_acc, rx_restart, rx_take;
  rx_rpt_t rpt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= 8'd1;
      func_code_r <= 8'd3;
      start_reg_r <= 16'd0;
      reg_count_r <= 16'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS: dev_addr_r  <= cfg_data[BYTE_W-1:0];
        CFG_FUNCTION_CODE:  func_code_r <= cfg_data[BYTE_W-1:0];
        CFG_START_REGISTER: start_reg_r <= cfg_data;
        CFG_REGISTER_COUNT: reg_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign slot_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = slot_free && !tx_busy_r;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign rx_restart   = in_acc && (in_ch.opcode == OP_REQUEST || in_ch.opcode == OP_TIMEOUT);
  assign rx_take      = in_acc && (in_ch.opcode == OP_RX_BYTE);

  mrfe_rx_check u_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (rx_restart),
    .take    (rx_take),
    .rx_byte (in_ch.rx_byte),
    .rpt     (rpt)
  );

  always_comb begin
    case (tx_idx_r)
      3'd0:    tx_sel = dev_addr_r;
      3'd1:    tx_sel = func_code_r;
      3'd2:    tx_sel = start_reg_r[15:8];
      3'd3:    tx_sel = start_reg_r[7:0];
      3'd4:    tx_sel = reg_count_r[15:8];
      3'd5:    tx_sel = reg_count_r[7:0];
      3'd6:    tx_sel = tx_crc_r[7:0];
      default: tx_sel = tx_crc_r[15:8];
    endcase
  end

  always_comb begin
    tx_busy_nxt = tx_busy_r;
    tx_idx_nxt  = tx_idx_r;
    tx_crc_nxt  = tx_crc_r;
    if (in_acc && in_ch.opcode == OP_REQUEST) begin
      tx_busy_nxt = 1'b1;
      tx_idx_nxt  = '0;
      tx_crc_nxt  = CRC_INIT;
    end else if (tx_busy_r && slot_free) begin
      tx_idx_nxt = tx_idx_r + 3'd1;
      // crc covers the six header bytes only
      if (tx_idx_r < 3'd6) begin
        tx_crc_nxt = crc16_byte(tx_crc_r, tx_sel);
      end
      if (tx_idx_r == 3'd7) begin
        tx_busy_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_item_nxt  = out_item_r;
    if (tx_busy_r && slot_free) begin
      out_valid_nxt            = 1'b1;
      out_item_nxt             = '0;
      out_item_nxt.kind        = KIND_TX;
      out_item_nxt.tx_byte     = tx_sel;
      out_item_nxt.last        = (tx_idx_r == 3'd7);
    end else if (in_acc && in_ch.opcode == OP_TIMEOUT) begin
      out_valid_nxt            = 1'b1;
      out_item_nxt             = '0;
      out_item_nxt.kind        = KIND_REPORT;
      out_item_nxt.last        = 1'b1;
      out_item_nxt.status      = ST_NO_RESP;
    end else if (rpt.valid) begin
      out_valid_nxt            = 1'b1;
      out_item_nxt             = '0;
      out_item_nxt.kind        = KIND_REPORT;
      out_item_nxt.last        = 1'b1;
      if (rpt.good) begin
        out_item_nxt.status      = ST_OK;
        out_item_nxt.first_word  = rpt.first_word;
        out_item_nxt.second_word = rpt.second_word;
      end else begin
        out_item_nxt.status      = ST_CRC_ERR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_busy_r   <= 1'b0;
      tx_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tx_busy_r   <= tx_busy_nxt;
      tx_idx_r    <= tx_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tx_crc_r   <= tx_crc_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_item_r.kind;
  assign out_ch.tx_byte     = out_item_r.tx_byte;
  assign out_ch.last        = out_item_r.last;
  assign out_ch.status      = out_item_r.status;
  assign out_ch.first_word  = out_item_r.first_word;
  assign out_ch.second_word = out_item_r.second_word;

endmodule
